[hdl/tkn_pkg.sv]
// Shared types and constants for the top-k newest keeper.
`timescale 1ns / 1ps

package tkn_pkg;

	// Fixed field widths of the beats.
	localparam int ENTRY_ID_W = 16;
	localparam int KEY_W      = 32;
	localparam int SLOT_W     = 6;
	localparam int ACTION_W   = 2;

	// Result codes.
	typedef enum logic [ACTION_W-1:0] {
		ACT_STORED   = 2'd0,
		ACT_REPLACED = 2'd1,
		ACT_REJECTED = 2'd2
	} action_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} seq_state_t;

	// Control strobes from the sequencer to the slot memory.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_cmd_t;

	// One result beat.
	typedef struct packed {
		action_t               action;
		logic [SLOT_W-1:0]     slot_index;
		logic [ENTRY_ID_W-1:0] removed_id;
	} result_t;

endpackage

[hdl/tkn_store.sv]
// Slot memory holding the kept keys and ids, one write and one registered read port.
`timescale 1ns / 1ps

module tkn_store #(
	parameter int CAPACITY = 5,
	parameter int ID_WIDTH = 16,
	parameter int AW       = 3
) (
	input  logic                 clk,
	input  tkn_pkg::mem_cmd_t    cmd,
	input  logic [AW-1:0]        wr_addr,
	input  logic [AW-1:0]        rd_addr,
	input  logic [tkn_pkg::KEY_W-1:0] wr_key,
	input  logic [ID_WIDTH-1:0]  wr_id,
	output logic [tkn_pkg::KEY_W-1:0] rd_key,
	output logic [ID_WIDTH-1:0]  rd_id
);
	import tkn_pkg::*;

	logic [KEY_W-1:0]    key_mem [CAPACITY];
	logic [ID_WIDTH-1:0] id_mem  [CAPACITY];

	// Write port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			key_mem[wr_addr] <= wr_key;
			id_mem[wr_addr]  <= wr_id;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_key <= key_mem[rd_addr];
			rd_id  <= id_mem[rd_addr];
		end
	end

endmodule

[hdl/tkn_seq.sv]
// Sequencer with the shared key comparator: fill, minimum scan and replace decision.
`timescale 1ns / 1ps

module tkn_seq #(
	parameter int CAPACITY = 5,
	parameter int ID_WIDTH = 16,
	parameter int AW       = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tkn_pkg::ENTRY_ID_W-1:0] entry_id,
	input  logic [tkn_pkg::KEY_W-1:0]     key_value,
	output tkn_pkg::mem_cmd_t             cmd,
	output logic [AW-1:0]                 wr_addr,
	output logic [AW-1:0]                 rd_addr,
	output logic [tkn_pkg::KEY_W-1:0]     wr_key,
	output logic [ID_WIDTH-1:0]           wr_id,
	input  logic [tkn_pkg::KEY_W-1:0]     rd_key,
	input  logic [ID_WIDTH-1:0]           rd_id,
	output logic                          res_en,
	output tkn_pkg::result_t              res
);
	import tkn_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	seq_state_t          state_q, state_d;
	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       cnt_q;
	logic [KEY_W-1:0]    key_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [KEY_W-1:0]    min_key_q;
	logic [ID_WIDTH-1:0] min_id_q;
	logic [AW-1:0]       min_idx_q;

	// Shared unsigned less-than unit.
	logic [KEY_W-1:0] cmp_a, cmp_b;
	logic             cmp_lt;
	assign cmp_lt = cmp_a < cmp_b;

	logic full;
	logic take_min;
	assign full     = fill_q == CAP_C;
	assign take_min = (state_q == ST_SCAN) && (cnt_q != '0) && ((cnt_q == ONE_C) || cmp_lt);
	assign busy     = state_q != ST_IDLE;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Fill count and scan counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (state_q == ST_IDLE) begin
				cnt_q <= '0;
				if (start && !full) begin
					fill_q <= fill_q + ONE_C;
				end
			end else if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + ONE_C;
			end
		end
	end

	// Incoming beat and running minimum.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			key_q <= key_value;
			id_q  <= ID_WIDTH'(entry_id);
		end
		if (take_min) begin
			min_key_q <= rd_key;
			min_id_q  <= rd_id;
			min_idx_q <= AW'(cnt_q - ONE_C);
		end
	end

	// Next state, memory control and result.
	always_comb begin
		state_d        = state_q;
		cmd.wr_en      = 1'b0;
		cmd.rd_en      = 1'b0;
		wr_addr        = '0;
		rd_addr        = cnt_q[AW-1:0];
		wr_key         = key_value;
		wr_id          = ID_WIDTH'(entry_id);
		cmp_a          = rd_key;
		cmp_b          = min_key_q;
		res_en         = 1'b0;
		res.action     = ACT_STORED;
		res.slot_index = '0;
		res.removed_id = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (!full) begin
						cmd.wr_en      = 1'b1;
						wr_addr        = fill_q[AW-1:0];
						res_en         = 1'b1;
						res.action     = ACT_STORED;
						res.slot_index = SLOT_W'(fill_q);
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				// Address cnt_q is issued while the data of cnt_q - 1 is compared.
				cmd.rd_en = cnt_q < CAP_C;
				if (cnt_q == CAP_C) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				// The new key wins only when strictly greater than the minimum.
				cmp_a   = min_key_q;
				cmp_b   = key_q;
				res_en  = 1'b1;
				state_d = ST_IDLE;
				if (cmp_lt) begin
					cmd.wr_en      = 1'b1;
					wr_addr        = min_idx_q;
					wr_key         = key_q;
					wr_id          = id_q;
					res.action     = ACT_REPLACED;
					res.slot_index = SLOT_W'(min_idx_q);
					res.removed_id = ENTRY_ID_W'(min_id_q);
				end else begin
					res.action     = ACT_REJECTED;
					res.removed_id = ENTRY_ID_W'(id_q);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The table never holds more entries than it has slots.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CAP_C)
		else $error("fill count beyond capacity");

	// A scan only runs on a full table.
	a_scan_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> full)
		else $error("scan started on a table that is not full");

	// Every write lands inside the table.
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (CW'(wr_addr) < CAP_C))
		else $error("write address outside the table");

	// A decision always follows the end of the scan and yields a result.
	a_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && cnt_q == CAP_C) |=> (state_q == ST_DECIDE && res_en))
		else $error("scan end not followed by a decision");

endmodule

[hdl/top_k_newest_keeper.sv]
// Top level of the top-k newest keeper: slot memory, sequencer and result register.
`timescale 1ns / 1ps

// Keeps the CAPACITY entries with the largest keys offered so far.
// Input: a beat is taken at a rising edge where start is high and busy is low;
// entry_id and key_value are sampled then.
// Output: one result beat per input, held on action, slot_index and removed_id
// for exactly one cycle while done is high. The receiver cannot stall, so the
// result is never held back.
// Timing: while the table is not full, an entry is written in the accept cycle,
// done follows in the next cycle and a new beat may be offered at once.
// Once full, a minimum search reads one slot per cycle through the single
// registered read port of the slot memory: busy stays high through the scan
// and the decision, done rises as busy falls, and the next beat can be taken
// once busy is low again.
// On equal keys the lowest slot counts as the smallest; an equal new key is
// rejected.
// Reset: arst_n clears the fill count and the sequencer; the table starts empty.
module top_k_newest_keeper #(
	parameter int CAPACITY = 5,
	parameter int ID_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [tkn_pkg::ENTRY_ID_W-1:0] entry_id,
	input  logic [tkn_pkg::KEY_W-1:0]      key_value,
	output logic                           done,
	output logic [tkn_pkg::ACTION_W-1:0]   action,
	output logic [tkn_pkg::SLOT_W-1:0]     slot_index,
	output logic [tkn_pkg::ENTRY_ID_W-1:0] removed_id
);
	import tkn_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	mem_cmd_t            cmd;
	logic [AW-1:0]       wr_addr, rd_addr;
	logic [KEY_W-1:0]    wr_key, rd_key;
	logic [ID_WIDTH-1:0] wr_id, rd_id;
	logic                res_en;
	result_t             res;
	result_t             res_q;
	logic                done_q;

	tkn_seq #(
		.CAPACITY (CAPACITY),
		.ID_WIDTH (ID_WIDTH),
		.AW       (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.entry_id  (entry_id),
		.key_value (key_value),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.wr_key    (wr_key),
		.wr_id     (wr_id),
		.rd_key    (rd_key),
		.rd_id     (rd_id),
		.res_en    (res_en),
		.res       (res)
	);

	tkn_store #(
		.CAPACITY (CAPACITY),
		.ID_WIDTH (ID_WIDTH),
		.AW       (AW)
	) u_store (
		.clk     (clk),
		.cmd     (cmd),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.wr_key  (wr_key),
		.wr_id   (wr_id),
		.rd_key  (rd_key),
		.rd_id   (rd_id)
	);

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_en;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (res_en) begin
			res_q <= res;
		end
	end

	assign done       = done_q;
	assign action     = res_q.action;
	assign slot_index = res_q.slot_index;
	assign removed_id = res_q.removed_id;

	// While a search runs, a result strobe is a single-cycle pulse; results can be adjacent only while the table fills.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && busy) |=> !done_q)
		else $error("result strobe held while a search runs");

	// The reported slot always lies inside the table.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (32'(slot_index) < 32'(CAPACITY)))
		else $error("reported slot outside the table");

	// A rejected entry reports slot zero.
	a_reject_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.action == ACT_REJECTED) |-> (slot_index == '0))
		else $error("rejected entry reports a slot");

endmodule
